@@ sv/svf_pkg.sv @@
// Shared types and constants for the Q15 state-variable filter.
// No dependencies; used by the interfaces, svf_cfg, svf_smul and the top level.
package svf_pkg;

  localparam int COEF_W    = 15;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 15;
  localparam int OUT_SHIFT = 16;

  localparam logic [COEF_W-1:0] FREQ_RST = 15'd16384;
  localparam logic [COEF_W-1:0] DAMP_RST = 15'd22937;
  localparam logic [COEF_W-1:0] DAMP_MIN = 15'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

  localparam logic [SAMPLE_W-1:0] Q15_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] Q15_MIN = 16'h8000;

  typedef enum logic [1:0] {
    MODE_LP    = 2'd0,
    MODE_HP    = 2'd1,
    MODE_BP    = 2'd2,
    MODE_NOTCH = 2'd3
  } svf_mode_t;

  typedef struct packed {
    logic [COEF_W-1:0] freq;
    logic [COEF_W-1:0] damp;
    svf_mode_t         mode;
  } svf_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PASS1 = 2'd1,
    ST_PASS2 = 2'd2,
    ST_DONE  = 2'd3
  } svf_state_t;

endpackage

@@ sv/svf_if.sv @@
// Valid/ready channel interfaces for the filter's input and result items.
// Depends on svf_pkg for the sample width.
interface svf_in_if import svf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       clear_state;

  modport source (output valid, output sample_in, output clear_state, input ready);
  modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface

interface svf_out_if import svf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

@@ sv/state_variable_filter_q15.sv @@
// Top level of the Q15 state-variable filter (lowpass/highpass/bandpass/notch).
// Depends on svf_pkg, svf_in_if, svf_out_if, svf_cfg and svf_smul.
//
// Usage:
//   in_ch carries one Q15 sample per item plus a clear flag that zeroes the
//   lowpass and bandpass accumulators before that sample is filtered.
//   out_ch returns one saturated Q15 sample per input item, in order.
//   cfg_we/cfg_index/cfg_wdata write freq_coeff (0), damping (1, clamped to
//   at least 1024) and filter_mode (2); other indexes are ignored. Write only
//   while no item is in flight.
// Operation:
//   Accumulators are processed bit-serially, LSB first, through serial-parallel
//   multipliers. Pass one forms f*bp and q*bp together and the new lowpass,
//   highpass and notch; pass two forms f*hp and the new bandpass. The done
//   state then registers the saturated output, waiting if out_ch is still full.
//   A new item is accepted only in the idle state, once the last result has
//   reached the output register, so items do not overlap in the filter.
// Reset and stalls:
//   Reset clears both accumulators, restores register defaults and empties the
//   output register. A finished result waits in the output register; the next
//   item is accepted meanwhile, and a further result waits until it is taken.
module state_variable_filter_q15 import svf_pkg::*; #(
  parameter int ACC_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  svf_in_if.sink               in_ch,
  svf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata
);

  localparam int NSTEP = ACC_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(NSTEP);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEP - 1);
  localparam logic [CNT_W-1:0] CNT_ADD  = CNT_W'(FRAC_BITS);
  localparam int HI_LSB = OUT_SHIFT + SAMPLE_W - 1;

  svf_cfg_t   cfg;
  svf_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ACC_WIDTH-1:0] lp_r, bp_r, hp_r, nt_r, in_r, mc_r;
  logic [ACC_WIDTH-1:0] hp_full, in_q31, sel;
  logic                 c_lp_r, c_nt_r, c_bp_r;
  logic [1:0]           c_hp_r;
  logic                 out_valid_r;
  logic [SAMPLE_W-1:0]  out_data_r, sat_val;

  logic in_acc, p1, p2, last, add_ph, done_go, mul_clr;
  logic pa_bit, pb_bit, lpn, hpb, ntb, bpn;
  logic [1:0] lp_s, nt_s, bp_s;
  logic [2:0] hp_s;
  logic [ACC_WIDTH-HI_LSB-1:0] hi_bits;

  svf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  svf_smul u_mul_f (
    .clk  (clk),
    .clr  (mul_clr),
    .step (p1 || p2),
    .coef (cfg.freq),
    .mbit (mc_r[0]),
    .pbit (pa_bit)
  );

  svf_smul u_mul_q (
    .clk  (clk),
    .clr  (mul_clr),
    .step (p1),
    .coef (cfg.damp),
    .mbit (mc_r[0]),
    .pbit (pb_bit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_PASS1;
      ST_PASS1: if (last) state_nxt = ST_PASS2;
      ST_PASS2: if (last) state_nxt = ST_DONE;
      ST_DONE:  if (done_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    p1          = 1'b0;
    p2          = 1'b0;
    done_go     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_PASS1: p1 = 1'b1;
      ST_PASS2: p2 = 1'b1;
      ST_DONE:  done_go = !out_valid_r || out_ch.ready;
      default:  in_ch.ready = 1'b0;
    endcase
  end

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign last    = (cnt_r == CNT_LAST);
  assign add_ph  = (cnt_r >= CNT_ADD);
  assign mul_clr = in_acc || (p1 && last);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc || ((p1 || p2) && last)) begin
      cnt_nxt = '0;
    end else if (p1 || p2) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // serial adders: lp += f*bp; hp = in - lp - q*bp; notch = hp + lp; bp += f*hp
  assign lp_s = {1'b0, lp_r[0]} + {1'b0, pa_bit} + {1'b0, c_lp_r};
  assign lpn  = lp_s[0];
  assign hp_s = {2'b0, in_r[0]} + {2'b0, ~lpn} + {2'b0, ~pb_bit} + {1'b0, c_hp_r};
  assign hpb  = hp_s[0];
  assign nt_s = {1'b0, hpb} + {1'b0, lpn} + {1'b0, c_nt_r};
  assign ntb  = nt_s[0];
  assign bp_s = {1'b0, bp_r[0]} + {1'b0, pa_bit} + {1'b0, c_bp_r};
  assign bpn  = bp_s[0];

  assign hp_full = {hpb, hp_r[ACC_WIDTH-1:1]};
  assign in_q31  = {{(ACC_WIDTH-OUT_SHIFT-SAMPLE_W){in_ch.sample_in[SAMPLE_W-1]}},
                    in_ch.sample_in, {OUT_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
      bp_r <= '0;
    end else begin
      if (in_acc && in_ch.clear_state) begin
        lp_r <= '0;
        bp_r <= '0;
      end
      if (p1 && add_ph) lp_r <= {lpn, lp_r[ACC_WIDTH-1:1]};
      if (p2 && add_ph) bp_r <= {bpn, bp_r[ACC_WIDTH-1:1]};
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r   <= in_q31;
      mc_r   <= in_ch.clear_state ? '0 : bp_r;
      c_lp_r <= 1'b0;
      c_hp_r <= 2'd2;
      c_nt_r <= 1'b0;
      c_bp_r <= 1'b0;
    end else begin
      if (p1 && last) begin
        mc_r <= hp_full;
      end else if (p1 || p2) begin
        mc_r <= {mc_r[ACC_WIDTH-1], mc_r[ACC_WIDTH-1:1]};
      end
      if (p1 && add_ph) begin
        in_r   <= {1'b0, in_r[ACC_WIDTH-1:1]};
        hp_r   <= hp_full;
        nt_r   <= {ntb, nt_r[ACC_WIDTH-1:1]};
        c_lp_r <= lp_s[1];
        c_hp_r <= hp_s[2:1];
        c_nt_r <= nt_s[1];
      end
      if (p2 && add_ph) c_bp_r <= bp_s[1];
    end
  end

  // output select and Q15 saturation
  always_comb begin
    case (cfg.mode)
      MODE_LP:    sel = lp_r;
      MODE_HP:    sel = hp_r;
      MODE_BP:    sel = bp_r;
      MODE_NOTCH: sel = nt_r;
      default:    sel = lp_r;
    endcase
  end

  assign hi_bits = sel[ACC_WIDTH-1:HI_LSB];

  always_comb begin
    if (sel[ACC_WIDTH-1] && !(&hi_bits)) begin
      sat_val = Q15_MIN;
    end else if (!sel[ACC_WIDTH-1] && (|hi_bits)) begin
      sat_val = Q15_MAX;
    end else begin
      sat_val = sel[OUT_SHIFT+SAMPLE_W-1:OUT_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) out_data_r <= sat_val;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

endmodule

@@ sv/svf_cfg.sv @@
// Configuration registers: frequency coefficient, clamped damping, output mode.
// Depends on svf_pkg.
module svf_cfg import svf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  output svf_cfg_t             cfg
);

  svf_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FREQ: cfg_nxt.freq = cfg_wdata;
        REG_DAMP: cfg_nxt.damp = (cfg_wdata < DAMP_MIN) ? DAMP_MIN : cfg_wdata;
        REG_MODE: cfg_nxt.mode = svf_mode_t'(cfg_wdata[1:0]);
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freq <= FREQ_RST;
      cfg_r.damp <= DAMP_RST;
      cfg_r.mode <= MODE_LP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/svf_smul.sv @@
// Serial-parallel multiplier: with step high, multiplicand enters LSB first, one
// bit per cycle, times a 15-bit coefficient; a product bit per cycle. Uses svf_pkg.
module svf_smul import svf_pkg::*; (
  input  logic              clk,
  input  logic              clr,
  input  logic              step,
  input  logic [COEF_W-1:0] coef,
  input  logic              mbit,
  output logic              pbit
);

  logic [COEF_W-1:0] part_r;
  logic [COEF_W:0]   sum;

  assign sum  = {1'b0, part_r} + (mbit ? {1'b0, coef} : '0);
  assign pbit = sum[0];

  always_ff @(posedge clk) begin
    if (clr) begin
      part_r <= '0;
    end else if (step) begin
      part_r <= sum[COEF_W:1];
    end
  end

endmodule
